FILE: src/eepps_pkg.sv
// Shared types and constants of the EEPROM page program sequencer.
package eepps_pkg;

  localparam int BUS_ADDR_W = 24;
  localparam int DATA_W     = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [DATA_W-1:0] POLL_MASK_RESET = 8'h80;

  localparam logic [BUS_ADDR_W-1:0] UNLOCK_ADDR_A = 24'h005555;
  localparam logic [BUS_ADDR_W-1:0] UNLOCK_ADDR_B = 24'h002AAA;
  localparam logic [DATA_W-1:0]     UNLOCK_DATA_1 = 8'hAA;
  localparam logic [DATA_W-1:0]     UNLOCK_DATA_2 = 8'h55;
  localparam logic [DATA_W-1:0]     UNLOCK_DATA_3 = 8'hA0;

  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_PAGE   = 2'd1,
    ST_RUN    = 2'd2,
    ST_REJECT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_REJECT,
    CMD_POLL,
    CMD_WRITE
  } cmd_kind_e;

  typedef enum logic [2:0] {
    BS_UNLOCK1,
    BS_UNLOCK2,
    BS_UNLOCK3,
    BS_DATA,
    BS_POLL
  } back_step_e;

  // One burst of bus cycles, as decided by the front end.
  typedef struct packed {
    cmd_kind_e               kind;
    logic                    unlock;
    logic                    poll;
    status_e                 poll_status;
    logic [DATA_W-1:0]       data;
    logic [BUS_ADDR_W-1:0]   addr;
  } eepps_cmd_t;

endpackage

FILE: src/eepps_in_if.sv
// Input channel of the sequencer: data bytes and poll read-back bytes.
interface eepps_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [23:0] start_addr;
  logic        first_byte;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [7:0]  read_byte;

  modport source (
    output valid, req_type, start_addr, first_byte, data_byte, last_byte, read_byte,
    input  ready
  );
  modport sink (
    input  valid, req_type, start_addr, first_byte, data_byte, last_byte, read_byte,
    output ready
  );
endinterface

FILE: src/eepps_out_if.sv
// Output channel of the sequencer: EEPROM bus cycles with status.
interface eepps_out_if;
  logic        valid;
  logic        ready;
  logic        bus_write;
  logic [23:0] bus_addr;
  logic [7:0]  bus_data;
  logic [1:0]  status;
  logic        end_of_burst;

  modport source (
    output valid, bus_write, bus_addr, bus_data, status, end_of_burst,
    input  ready
  );
  modport sink (
    input  valid, bus_write, bus_addr, bus_data, status, end_of_burst,
    output ready
  );
endinterface

FILE: src/eepps_front.sv
// Front end: accepts items, tracks run and polling state, emits burst commands.
module eepps_front #(
  parameter int PAGE_BYTES = 64,
  parameter int ADDR_BITS  = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  eepps_in_if.sink               in_i,
  input  logic                   poll_mask_we_i,
  input  logic [7:0]             poll_mask_i,
  output logic                   push_valid_o,
  output eepps_pkg::eepps_cmd_t  push_cmd_o,
  input  logic                   push_ready_i
);
  import eepps_pkg::*;

  localparam int PosW = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
  localparam logic [PosW-1:0] PosLast = PosW'(PAGE_BYTES - 1);

  logic [DATA_W-1:0]     poll_mask_q;
  logic [ADDR_BITS-1:0]  next_addr_q, next_addr_d;
  logic [PosW-1:0]       pos_q, pos_d;
  logic [DATA_W-1:0]     wr_byte_q, wr_byte_d;
  logic [BUS_ADDR_W-1:0] wr_addr_q, wr_addr_d;
  logic                  polling_q, polling_d;
  logic                  run_end_q, run_end_d;

  logic                  accept;
  logic [31:0]           start_ext;
  logic [31:0]           addr_ext;
  logic [ADDR_BITS-1:0]  addr_eff;
  logic [PosW-1:0]       pos_eff;
  logic                  page_wrap;
  logic                  match;

  assign in_i.ready = push_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  assign start_ext = 32'(in_i.start_addr);
  assign addr_eff  = in_i.first_byte ? start_ext[ADDR_BITS-1:0] : next_addr_q;
  assign addr_ext  = 32'(addr_eff);
  assign pos_eff   = in_i.first_byte ? '0 : pos_q;
  assign page_wrap = (pos_eff == PosLast);
  assign match     = (((in_i.read_byte ^ wr_byte_q) & poll_mask_q) == '0);

  always_comb begin
    next_addr_d  = next_addr_q;
    pos_d        = pos_q;
    wr_byte_d    = wr_byte_q;
    wr_addr_d    = wr_addr_q;
    polling_d    = polling_q;
    run_end_d    = run_end_q;
    push_valid_o = 1'b0;

    push_cmd_o             = '0;
    push_cmd_o.kind        = CMD_REJECT;
    push_cmd_o.poll_status = run_end_q ? ST_RUN : ST_PAGE;
    push_cmd_o.addr        = wr_addr_q;

    if (accept) begin
      if (in_i.req_type == REQ_READ) begin
        if (!polling_q) begin
          push_valid_o = 1'b1;
        end else if (match) begin
          polling_d = 1'b0;
          run_end_d = 1'b0;
        end else begin
          push_valid_o    = 1'b1;
          push_cmd_o.kind = CMD_POLL;
        end
      end else if (polling_q) begin
        push_valid_o = 1'b1;
      end else begin
        push_valid_o      = 1'b1;
        push_cmd_o.kind   = CMD_WRITE;
        push_cmd_o.unlock = (pos_eff == '0);
        push_cmd_o.data   = in_i.data_byte;
        push_cmd_o.addr   = addr_ext[BUS_ADDR_W-1:0];
        wr_byte_d         = in_i.data_byte;
        wr_addr_d         = addr_ext[BUS_ADDR_W-1:0];
        next_addr_d       = addr_eff + ADDR_BITS'(1);
        if (in_i.last_byte) begin
          run_end_d              = 1'b1;
          polling_d              = 1'b1;
          pos_d                  = '0;
          push_cmd_o.poll        = 1'b1;
          push_cmd_o.poll_status = ST_RUN;
        end else if (page_wrap) begin
          run_end_d              = 1'b0;
          polling_d              = 1'b1;
          pos_d                  = '0;
          push_cmd_o.poll        = 1'b1;
          push_cmd_o.poll_status = ST_PAGE;
        end else begin
          pos_d = pos_eff + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_mask_q <= POLL_MASK_RESET;
      next_addr_q <= '0;
      pos_q       <= '0;
      wr_byte_q   <= '0;
      wr_addr_q   <= '0;
      polling_q   <= 1'b0;
      run_end_q   <= 1'b0;
    end else begin
      if (poll_mask_we_i) begin
        poll_mask_q <= poll_mask_i;
      end
      next_addr_q <= next_addr_d;
      pos_q       <= pos_d;
      wr_byte_q   <= wr_byte_d;
      wr_addr_q   <= wr_addr_d;
      polling_q   <= polling_d;
      run_end_q   <= run_end_d;
    end
  end

endmodule

FILE: src/eepps_queue.sv
// Short command queue between the front end and the bus cycle generator.
module eepps_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_valid_i,
  input  eepps_pkg::eepps_cmd_t  push_cmd_i,
  output logic                   push_ready_o,
  output logic                   pop_valid_o,
  output eepps_pkg::eepps_cmd_t  pop_cmd_o,
  input  logic                   pop_ready_i
);
  import eepps_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);

  eepps_cmd_t          mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]       count_q, count_d;
  logic                push, pop;

  assign push_ready_o = (count_q != (PtrW + 1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + (PtrW + 1)'(1);
    end else if (pop && !push) begin
      count_d = count_q - (PtrW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_d;
    end
  end

endmodule

FILE: src/eepps_back.sv
// Back end: expands each command into its run of EEPROM bus cycles.
module eepps_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   pop_valid_i,
  input  eepps_pkg::eepps_cmd_t  pop_cmd_i,
  output logic                   pop_ready_o,
  eepps_out_if.source            out_o
);
  import eepps_pkg::*;

  back_step_e  step_q, step_d;
  logic        active_q, active_d;
  eepps_cmd_t  cmd_q, cmd_d;

  logic        fire;
  logic        last;
  back_step_e  step_next;
  back_step_e  step_first;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= BS_POLL;
      active_q <= 1'b0;
    end else begin
      step_q   <= step_d;
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  always_comb begin
    out_o.valid        = active_q;
    out_o.bus_write    = 1'b1;
    out_o.bus_addr     = '0;
    out_o.bus_data     = '0;
    out_o.status       = ST_OK;
    out_o.end_of_burst = 1'b0;
    last               = 1'b0;
    step_next          = step_q;

    case (step_q)
      BS_UNLOCK1: begin
        out_o.bus_addr = UNLOCK_ADDR_A;
        out_o.bus_data = UNLOCK_DATA_1;
        step_next      = BS_UNLOCK2;
      end
      BS_UNLOCK2: begin
        out_o.bus_addr = UNLOCK_ADDR_B;
        out_o.bus_data = UNLOCK_DATA_2;
        step_next      = BS_UNLOCK3;
      end
      BS_UNLOCK3: begin
        out_o.bus_addr = UNLOCK_ADDR_A;
        out_o.bus_data = UNLOCK_DATA_3;
        step_next      = BS_DATA;
      end
      BS_DATA: begin
        out_o.bus_addr = cmd_q.addr;
        out_o.bus_data = cmd_q.data;
        last           = !cmd_q.poll;
        step_next      = BS_POLL;
      end
      BS_POLL: begin
        out_o.bus_write = 1'b0;
        last            = 1'b1;
        if (cmd_q.kind == CMD_REJECT) begin
          out_o.status = ST_REJECT;
        end else begin
          out_o.bus_addr = cmd_q.addr;
          out_o.status   = cmd_q.poll_status;
        end
      end
      default: begin
        last = 1'b1;
      end
    endcase
    out_o.end_of_burst = last;

    fire = active_q && out_o.ready;

    if (pop_cmd_i.kind != CMD_WRITE) begin
      step_first = BS_POLL;
    end else if (pop_cmd_i.unlock) begin
      step_first = BS_UNLOCK1;
    end else begin
      step_first = BS_DATA;
    end

    // A new command is taken when idle or as the last cycle of the current one leaves.
    pop_ready_o = !active_q || (fire && last);
    step_d      = step_q;
    active_d    = active_q;
    cmd_d       = cmd_q;
    if (pop_ready_o && pop_valid_i) begin
      cmd_d    = pop_cmd_i;
      active_d = 1'b1;
      step_d   = step_first;
    end else if (fire && last) begin
      active_d = 1'b0;
    end else if (fire) begin
      step_d = step_next;
    end
  end

endmodule

FILE: src/eeprom_page_program_sequencer_unit.sv
// An accepted item is registered in the command queue, then in the bus cycle generator.
// Throughput: one bus cycle per clock while out_o.ready is high; a data byte
// costs its write, plus the unlock cycles at the first byte of a page or run
// and a poll read at its last byte. The bus cycle generator sets this rate.
// Reset (rst_ni, asynchronous, active low) clears run and polling state and
// sets poll_mask to 0x80.
module eeprom_page_program_sequencer_unit #(
  parameter int PAGE_BYTES = 64,
  parameter int ADDR_BITS  = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  eepps_in_if.sink    in_i,
  eepps_out_if.source out_o,
  input  logic        poll_mask_we_i,
  input  logic [7:0]  poll_mask_i
);
  import eepps_pkg::*;

  logic        push_valid, push_ready;
  eepps_cmd_t  push_cmd;
  logic        pop_valid, pop_ready;
  eepps_cmd_t  pop_cmd;

  eepps_front #(
    .PAGE_BYTES (PAGE_BYTES),
    .ADDR_BITS  (ADDR_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_i),
    .poll_mask_we_i (poll_mask_we_i),
    .poll_mask_i    (poll_mask_i),
    .push_valid_o   (push_valid),
    .push_cmd_o     (push_cmd),
    .push_ready_i   (push_ready)
  );

  eepps_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_cmd_o    (pop_cmd),
    .pop_ready_i  (pop_ready)
  );

  eepps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_cmd_i   (pop_cmd),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule
